>>> hdl/adcreg_pkg.sv
// Shared definitions for the ADC engine register file: word map, state codes,
// write masks and reset values of the register store.
// Depends on nothing; used by adc_engine_register_model.
`default_nettype none

package adcreg_pkg;

	localparam int unsigned REG_WORDS = 64;
	localparam int unsigned WORD_AW   = $clog2(REG_WORDS);

	// Word map of the register window (byte address / 4).
	localparam logic [WORD_AW-1:0] W_ENGINE = WORD_AW'(0);
	localparam logic [WORD_AW-1:0] W_IRQCTL = WORD_AW'(1);
	localparam logic [WORD_AW-1:0] W_VGA    = WORD_AW'(2);
	localparam logic [WORD_AW-1:0] W_CLOCK  = WORD_AW'(3);
	localparam logic [WORD_AW-1:0] W_DATA0  = WORD_AW'(4);
	localparam logic [WORD_AW-1:0] W_DATA4  = WORD_AW'(8);
	localparam logic [WORD_AW-1:0] W_BOUND0 = WORD_AW'(12);
	localparam logic [WORD_AW-1:0] W_BOUND8 = WORD_AW'(20);
	localparam logic [WORD_AW-1:0] W_HYST0  = WORD_AW'(28);
	localparam logic [WORD_AW-1:0] W_HYST8  = WORD_AW'(36);
	localparam logic [WORD_AW-1:0] W_HYSTE  = WORD_AW'(44);
	localparam logic [WORD_AW-1:0] W_IRQSRC = WORD_AW'(48);
	localparam logic [WORD_AW-1:0] W_TRIM   = WORD_AW'(49);

	localparam logic [31:0] PAIR_MASK   = 32'h03FF_03FF;
	localparam logic [31:0] HYST_MASK   = 32'h83FF_03FF;
	localparam logic [31:0] IRQSRC_MASK = 32'h0000_FFFF;
	localparam logic [31:0] TRIM_MASK   = 32'h0000_000F;
	localparam logic [31:0] VGA_CLK_RST = 32'h0000_000F;

	localparam logic [9:0] LOW_STEP  = 10'd5;
	localparam logic [10:0] HIGH_STEP = 11'd7;

	// Sequencer state codes.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_BA   = 3'd2;
	localparam logic [2:0] ST_BB   = 3'd3;
	localparam logic [2:0] ST_IC   = 3'd4;
	localparam logic [2:0] ST_PUT  = 3'd5;

	typedef logic [WORD_AW-1:0] word_idx_t;

	typedef struct packed {
		logic is_data;
		logic is_bound;
		logic is_hyst;
		logic upper;
		logic readable;
	} addr_class_t;

	function automatic addr_class_t classify(input word_idx_t w);
		addr_class_t c;
		c.is_data  = (w >= W_DATA0) && (w < W_BOUND0);
		c.is_bound = (w >= W_BOUND0) && (w < W_HYST0);
		c.is_hyst  = (w >= W_HYST0) && (w < W_HYSTE);
		c.upper    = (c.is_data && (w >= W_DATA4)) || (c.is_bound && (w >= W_BOUND8)) ||
			(c.is_hyst && (w >= W_HYST8));
		c.readable = c.is_bound || c.is_hyst || (w <= W_CLOCK) || (w == W_IRQSRC) ||
			(w == W_TRIM);
		return c;
	endfunction

	function automatic logic [31:0] write_mask(input word_idx_t w, input logic [31:0] v);
		addr_class_t c;
		logic [31:0] r;
		c = classify(w);
		r = v;
		if (w == W_ENGINE) begin
			r[8] = v[0];
			r[5] = 1'b0;
		end else if (c.is_data || c.is_bound) begin
			r = v & PAIR_MASK;
		end else if (c.is_hyst) begin
			r = v & HYST_MASK;
		end else if (w == W_IRQSRC) begin
			r = v & IRQSRC_MASK;
		end else if (w == W_TRIM) begin
			r = v & TRIM_MASK;
		end
		return r;
	endfunction

	function automatic logic [31:0] reset_value(input word_idx_t w);
		return ((w == W_VGA) || (w == W_CLOCK)) ? VGA_CLK_RST : 32'd0;
	endfunction

	// True when a 10-bit sample lies outside the limits of a bounds word.
	function automatic logic out_of_bounds(input logic [9:0] sample, input logic [31:0] bounds);
		return (sample < bounds[9:0]) || (sample > bounds[25:16]);
	endfunction

endpackage

`default_nettype wire

>>> hdl/adc_engine_register_model.sv
// Register file of one ADC engine behind a request/response stream interface.
// Depends on adcreg_pkg for the word map, masks and reset values.
//
// Usage:
// - Requests enter on the s_* channel: s_tuser is the command (0 read, 1 write),
//   s_tdata carries the byte address and the write data. One response leaves on
//   the m_* channel for every request: m_tdata is the read data (0 for writes,
//   ignored and unknown addresses), m_tuser is the irq pulse.
// - The 64-word store sits in a single synchronous RAM with a registered read.
//   A sequencer walks each request through it one access per cycle, holding in
//   its hand-off step while the output register is full, so one request is in
//   flight at a time and s_tready is high only while it is idle.
// - A write, an ignored access or an unknown read goes straight from accept to
//   the hand-off step. A plain register read first reads its word; a data-pair
//   read then also reads the two bounds words and, when it raises an interrupt,
//   does the read-modify-write of the interrupt-control word, before the response
//   is handed off.
// - The response sits in an output register. If the receiver stalls, the
//   sequencer still accepts the next request and works it up to its response,
//   then holds until the output register frees up.
// - Reset clears the control state and the per-word valid bits; a word never
//   written reads as its reset value (0xf for vga and clock, zero elsewhere), so
//   no clearing pass is needed. The channel-count register resets to sixteen.
// - The configuration channel is always ready; write it only while idle.
`default_nettype none

module adc_engine_register_model
	import adcreg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request channel.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [7:0] byte_address, [39:8] write_data
	input  wire logic        s_tuser,   // [0] command
	// Response channel.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [31:0] read_data
	output logic             m_tuser,   // [0] irq_pulse
	// Channel-count register.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data   // [0] sixteen_channels
);

	logic [31:0] mem [REG_WORDS];
	logic [REG_WORDS-1:0] valid_q;

	logic [2:0]  state_q;
	logic        sixteen_q;
	word_idx_t   word_q;
	logic        half_q;
	logic        is_data_q;
	logic [31:0] old_q;
	logic [31:0] next_q;
	logic        viol_q;
	logic [31:0] res_data_q;
	logic        res_irq_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_irq_q;

	logic [31:0] rdata_s1;
	logic        rvalid_s1;
	word_idx_t   raddr_s1;

	logic        s_accept;
	logic        out_free;
	word_idx_t   in_word;
	addr_class_t in_class;
	logic        ignored;
	logic        mem_we;
	word_idx_t   waddr;
	logic [31:0] wdata;
	word_idx_t   raddr;
	logic [31:0] rword;
	logic [2:0]  pair;
	logic [31:0] sample_next;
	logic        viol_b;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_irq_q;

	assign in_word  = s_tdata[7:2];
	assign in_class = classify(in_word);
	assign ignored  = in_class.upper && !sixteen_q;

	assign pair  = 3'(word_q - W_DATA0);
	assign rword = rvalid_s1 ? rdata_s1 : reset_value(raddr_s1);

	// Next sample, built from the pair word as it arrives from the RAM: the low
	// channel steps by 5 modulo 1024, the upper channel by 7 into 11 bits.
	assign sample_next = {5'd0, {1'b0, rword[25:16]} + HIGH_STEP, 6'd0, rword[9:0] + LOW_STEP};
	assign viol_b      = viol_q || out_of_bounds(next_q[25:16], rword);

	// Memory access selection for each sequencer step.
	always_comb begin
		mem_we = 1'b0;
		waddr  = word_q;
		wdata  = 32'd0;
		raddr  = in_word;
		unique case (state_q)
			ST_IDLE: begin
				mem_we = s_accept && s_tuser && !ignored;
				waddr  = in_word;
				wdata  = write_mask(in_word, s_tdata[39:8]);
			end
			ST_RD: begin
				mem_we = is_data_q;
				waddr  = word_q;
				wdata  = sample_next;
				raddr  = W_BOUND0 + {2'b00, pair, 1'b0};
			end
			ST_BA: begin
				raddr = W_BOUND0 + {2'b00, pair, 1'b1};
			end
			ST_BB: begin
				raddr = W_IRQCTL;
			end
			ST_IC: begin
				mem_we = 1'b1;
				waddr  = W_IRQCTL;
				wdata  = rword | (32'd1 << pair);
			end
			ST_PUT: begin
				raddr = word_q;
			end
			default: begin
				raddr = in_word;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
			raddr_s1  <= '0;
		end else begin
			if (mem_we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvalid_s1 <= valid_q[raddr] || (mem_we && (waddr == raddr));
			raddr_s1  <= raddr;
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sixteen_q   <= 1'b1;
			out_valid_q <= 1'b0;
			out_data_q  <= 32'd0;
			out_irq_q   <= 1'b0;
			word_q      <= '0;
			half_q      <= 1'b0;
			is_data_q   <= 1'b0;
			old_q       <= 32'd0;
			next_q      <= 32'd0;
			viol_q      <= 1'b0;
			res_data_q  <= 32'd0;
			res_irq_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sixteen_q <= cfg_data;
			end
			// The hand-off step below reloads the output register in the same cycle.
			if (m_tready && !(state_q == ST_PUT && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						word_q     <= in_word;
						half_q     <= s_tdata[1];
						is_data_q  <= in_class.is_data;
						res_data_q <= 32'd0;
						res_irq_q  <= 1'b0;
						if (!s_tuser && !ignored && (in_class.is_data || in_class.readable)) begin
							state_q <= ST_RD;
						end else begin
							state_q <= ST_PUT;
						end
					end
				end
				ST_RD: begin
					if (is_data_q) begin
						old_q   <= rword;
						next_q  <= sample_next;
						state_q <= ST_BA;
					end else begin
						res_data_q <= rword;
						state_q    <= ST_PUT;
					end
				end
				ST_BA: begin
					viol_q  <= out_of_bounds(next_q[9:0], rword);
					state_q <= ST_BB;
				end
				ST_BB: begin
					res_data_q <= half_q ? {16'd0, old_q[31:16]} : old_q;
					res_irq_q  <= viol_b;
					state_q    <= viol_b ? ST_IC : ST_PUT;
				end
				ST_IC: begin
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_data_q;
						out_irq_q   <= res_irq_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The interrupt-control update happens only for a read that found a violation.
	a_ic_has_irq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IC) |-> res_irq_q)
		else $error("interrupt-control update without a pending irq");

	// A data-pair read always goes on to fetch its bounds.
	a_data_to_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD && is_data_q) |=> (state_q == ST_BA))
		else $error("data-pair read skipped the bounds check");

	// A stalled response holds its fields until the receiver takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("response changed while stalled");

	// An accepted request always leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (state_q != ST_IDLE))
		else $error("request accepted but sequencer stayed idle");

	// A raised irq on the response belongs to a data-pair read.
	a_irq_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT && res_irq_q) |-> is_data_q)
		else $error("irq raised for a non data-pair access");

endmodule

`default_nettype wire
